[hdl/rncs_pkg.sv]
`timescale 1ns / 1ps
package rncs_pkg;

    typedef struct packed {
        logic [2:0][31:0] vel;
        logic [2:0][31:0] pos;
    } node_t;

    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_SET_POS = 3'd1;
    localparam logic [2:0] REQ_SET_VEL = 3'd2;
    localparam logic [2:0] REQ_ADD_POS = 3'd3;
    localparam logic [2:0] REQ_ADD_VEL = 3'd4;
    localparam logic [2:0] REQ_READ    = 3'd5;

    localparam logic [2:0] REG_FRICTION = 3'd0;
    localparam logic [2:0] REG_GRAVITY  = 3'd1;
    localparam logic [2:0] REG_STIFF    = 3'd2;
    localparam logic [2:0] REG_SEGLEN   = 3'd3;
    localparam logic [2:0] REG_PULL     = 3'd4;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        if (v > SAT_HI) begin
            return 32'h7FFF_FFFF;
        end else if (v < SAT_LO) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [65:0] sx32(input logic [31:0] x);
        return {{34{x[31]}}, x};
    endfunction

endpackage

[hdl/rncs_mem.sv]
`timescale 1ns / 1ps
module rncs_mem
    import rncs_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output node_t                    rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  node_t                    wr_data
);

    node_t            mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    node_t            q_reg;
    logic             q_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                q_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

[hdl/rncs_sqrt.sv]
`timescale 1ns / 1ps
module rncs_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (x_reg >= trial) begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == 64'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

[hdl/rncs_div.sv]
`timescale 1ns / 1ps
module rncs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dv_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, dv_reg};
    assign ge    = trial >= {1'b0, dv_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[63:32];
            quo_reg <= dividend[31:0];
            dv_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/rope_node_chain_step_top.sv]
`timescale 1ns / 1ps
// Rope node chain. Requests arrive on the s_ stream: tuser carries the request
// type, tdata the node index and a vector. Results leave on the m_ stream, with
// tlast on the final result of a run. Parameters sit behind the APB port.
// A tick damps, accelerates and moves every free node,
// then runs the backward and forward constraint passes, one pair at a time.
// A pair within length is only written back; a stretched pair also runs
// the 32-step square root and the six 32-step divisions of the shared
// iterative units.
// Set and add requests read the node and write it back; a read gives one result.
// One request is worked on at a time; s_tready is low while one is in progress.
// The node state sits in one synchronous memory with a valid bit per entry, so
// reset clears all nodes at once and no clearing pass is needed.
// A result waits in the output register while the receiver stalls; the block
// then holds further results of the run until the register is free.
module rope_node_chain_step_top
    import rncs_pkg::*;
#(
    parameter int NODE_COUNT = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // node_index, vec_x, vec_y, vec_z, zero pad
    input  logic [2:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // out_node, pos_x/y/z, vel_x/y/z, zero pad
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int NE = (NODE_COUNT < 8) ? NODE_COUNT : 8;
    localparam logic [AW-1:0] LAST_A  = AW'(NODE_COUNT - 1);
    localparam logic [AW-1:0] BACK_A  = AW'(NODE_COUNT - 2);
    localparam logic [2:0]    E_LAST  = 3'(NE - 1);

    typedef enum logic [23:0] {
        S_IDLE    = 24'h000001,
        S_UPD     = 24'h000002,
        S_INT_ISS = 24'h000004,
        S_INT_CAP = 24'h000008,
        S_INT_MUL = 24'h000010,
        S_INT_ACC = 24'h000020,
        S_INT_WR  = 24'h000040,
        S_P_ISS   = 24'h000080,
        S_P_CPA   = 24'h000100,
        S_P_CPB   = 24'h000200,
        S_P_DIF   = 24'h000400,
        S_P_SQ    = 24'h000800,
        S_P_SQACC = 24'h001000,
        S_P_LL    = 24'h002000,
        S_P_CMP   = 24'h004000,
        S_P_SQRT  = 24'h008000,
        S_P_KM    = 24'h010000,
        S_P_K     = 24'h020000,
        S_P_MUL   = 24'h040000,
        S_P_DIVS  = 24'h080000,
        S_P_DIVW  = 24'h100000,
        S_P_WR    = 24'h200000,
        S_E_ISS   = 24'h400000,
        S_E_CAP   = 24'h800000
    } state_t;

    function automatic logic [AW-1:0] to_addr(input logic [2:0] x);
        logic [6:0] w;
        w = {4'b0, x};
        return w[AW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [16:0] friction_reg;
    logic [19:0] grav_reg;
    logic [16:0] stiff_reg;
    logic [30:0] seglen_reg;
    logic [30:0] pull_reg;

    logic [AW-1:0]    cnt_reg;
    logic             back_reg;
    logic [1:0]       ax_reg;
    logic             kick_reg;
    logic [2:0]       e_reg;
    logic             rmode_reg;
    logic             rzero_reg;
    logic [2:0]       req_reg;
    logic [2:0]       idx_reg;
    logic [2:0][31:0] vec_reg;
    logic [2:0][31:0] apos_reg;
    node_t            b_reg;
    logic [2:0][31:0] d_reg;
    logic [63:0]      s_reg;
    logic [31:0]      mag_reg;
    logic [30:0]      k_reg;
    logic signed [65:0] prod_reg;

    logic         m_valid_reg;
    logic [194:0] m_data_reg;
    logic         m_last_reg;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    node_t         rd_data, wr_data, upd_data;
    logic [AW-1:0] one_addr;
    logic          accept, idx_ok, slot_free;
    logic          sqrt_start, sqrt_done, div_start, div_done;
    logic [31:0]   sqrt_root, div_quo;
    logic signed [32:0] ma, mb;
    logic [31:0]   absd, fv, gv, np, ld_pos, ld_vel;
    logic [49:0]   kraw;
    logic signed [65:0] sq;
    logic [2:0][31:0] dif;
    node_t         out_node_data;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE) && aresetn;
    assign accept   = s_tvalid && s_tready;
    assign idx_ok   = {4'b0, s_tdata[2:0]} < 7'(NODE_COUNT);
    assign slot_free = !m_valid_reg || m_tready;
    assign one_addr = back_reg ? cnt_reg + AW'(1) : cnt_reg - AW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            friction_reg <= 17'd63570;
            grav_reg     <= 20'hFF000;
            stiff_reg    <= 17'd52429;
            seglen_reg   <= 31'd40960;
            pull_reg     <= 31'd409600;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_FRICTION: friction_reg <= pwdata[16:0];
                REG_GRAVITY:  grav_reg     <= pwdata[19:0];
                REG_STIFF:    stiff_reg    <= pwdata[16:0];
                REG_SEGLEN:   seglen_reg   <= pwdata[30:0];
                REG_PULL:     pull_reg     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_FRICTION: prdata = 32'(friction_reg);
            REG_GRAVITY:  prdata = 32'(grav_reg);
            REG_STIFF:    prdata = 32'(stiff_reg);
            REG_SEGLEN:   prdata = 32'(seglen_reg);
            REG_PULL:     prdata = 32'(pull_reg);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        upd_data = rd_data;
        for (int a = 0; a < 3; a++) begin
            case (req_reg)
                REQ_SET_POS: upd_data.pos[a] = vec_reg[a];
                REQ_SET_VEL: upd_data.vel[a] = vec_reg[a];
                REQ_ADD_POS: upd_data.pos[a] = sat32(sx32(rd_data.pos[a]) + sx32(vec_reg[a]));
                REQ_ADD_VEL: upd_data.vel[a] = sat32(sx32(rd_data.vel[a]) + sx32(vec_reg[a]));
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            dif[a] = sat32(sx32(apos_reg[a]) - sx32(b_reg.pos[a]));
        end
    end

    assign fv = sat32(prod_reg >>> 16);
    assign gv = (ax_reg == 2'd1) ? sat32(sx32(fv) + {{46{grav_reg[19]}}, grav_reg}) : fv;
    assign np = sat32(sx32(b_reg.pos[ax_reg]) + sx32(gv));
    assign absd = d_reg[ax_reg][31] ? (~d_reg[ax_reg] + 32'd1) : d_reg[ax_reg];
    assign kraw = prod_reg[65:16];
    assign sq = d_reg[ax_reg][31] ? -{34'b0, div_quo} : {34'b0, div_quo};
    assign ld_pos = sat32(sx32(apos_reg[ax_reg]) - sq);
    assign ld_vel = sat32(sx32(b_reg.vel[ax_reg]) + sq);

    always_comb begin
        ma = {1'b0, absd};
        mb = kick_reg ? {2'b0, k_reg} : {2'b0, seglen_reg};
        case (state_reg)
            S_INT_MUL: begin
                ma = {b_reg.vel[ax_reg][31], b_reg.vel[ax_reg]};
                mb = {16'b0, friction_reg};
            end
            S_P_SQ: begin
                ma = {d_reg[ax_reg][31], d_reg[ax_reg]};
                mb = {d_reg[ax_reg][31], d_reg[ax_reg]};
            end
            S_P_LL: begin
                ma = {2'b0, seglen_reg};
                mb = {2'b0, seglen_reg};
            end
            S_P_KM: begin
                ma = {16'b0, stiff_reg};
                mb = {1'b0, mag_reg - {1'b0, seglen_reg}};
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = cnt_reg;
        wr_en      = 1'b0;
        wr_addr    = cnt_reg;
        wr_data    = b_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_tuser) inside
                        REQ_TICK: begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(1);
                            state_next = S_INT_CAP;
                        end
                        [REQ_SET_POS:REQ_ADD_VEL]: begin
                            if (idx_ok) begin
                                rd_en      = 1'b1;
                                rd_addr    = to_addr(s_tdata[2:0]);
                                state_next = S_UPD;
                            end
                        end
                        REQ_READ: begin
                            rd_en      = idx_ok;
                            rd_addr    = to_addr(s_tdata[2:0]);
                            state_next = S_E_CAP;
                        end
                        default: ;
                    endcase
                end
            end
            S_UPD: begin
                wr_en      = 1'b1;
                wr_addr    = to_addr(idx_reg);
                wr_data    = upd_data;
                state_next = S_IDLE;
            end
            S_INT_ISS: begin
                rd_en      = 1'b1;
                state_next = S_INT_CAP;
            end
            S_INT_CAP: state_next = S_INT_MUL;
            S_INT_MUL: state_next = S_INT_ACC;
            S_INT_ACC: state_next = (ax_reg == 2'd2) ? S_INT_WR : S_INT_MUL;
            S_INT_WR: begin
                wr_en      = 1'b1;
                state_next = (cnt_reg == LAST_A) ? S_P_ISS : S_INT_ISS;
            end
            S_P_ISS: begin
                rd_en      = 1'b1;
                rd_addr    = one_addr;
                state_next = S_P_CPA;
            end
            S_P_CPA: begin
                rd_en      = 1'b1;
                state_next = S_P_CPB;
            end
            S_P_CPB:   state_next = S_P_DIF;
            S_P_DIF:   state_next = S_P_SQ;
            S_P_SQ:    state_next = S_P_SQACC;
            S_P_SQACC: state_next = (ax_reg == 2'd2) ? S_P_LL : S_P_SQ;
            S_P_LL:    state_next = S_P_CMP;
            S_P_CMP: begin
                if (s_reg <= prod_reg[63:0]) begin
                    state_next = S_P_WR;
                end else begin
                    sqrt_start = 1'b1;
                    state_next = S_P_SQRT;
                end
            end
            S_P_SQRT: if (sqrt_done) state_next = S_P_KM;
            S_P_KM:   state_next = S_P_K;
            S_P_K:    state_next = S_P_MUL;
            S_P_MUL:  state_next = S_P_DIVS;
            S_P_DIVS: begin
                div_start  = 1'b1;
                state_next = S_P_DIVW;
            end
            S_P_DIVW: begin
                if (div_done) begin
                    state_next = (kick_reg && ax_reg == 2'd2) ? S_P_WR : S_P_MUL;
                end
            end
            S_P_WR: begin
                wr_en      = 1'b1;
                state_next = (!back_reg && cnt_reg == LAST_A) ? S_E_ISS : S_P_ISS;
            end
            S_E_ISS: begin
                rd_en      = 1'b1;
                rd_addr    = to_addr(e_reg);
                state_next = S_E_CAP;
            end
            S_E_CAP: begin
                if (slot_free) begin
                    state_next = (rmode_reg || e_reg == E_LAST) ? S_IDLE : S_E_ISS;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_E_CAP && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign out_node_data = rzero_reg ? '0 : rd_data;

    always_ff @(posedge aclk) begin
        prod_reg <= 66'(ma) * 66'(mb);
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_reg    <= s_tuser;
                    idx_reg    <= s_tdata[2:0];
                    vec_reg[0] <= s_tdata[34:3];
                    vec_reg[1] <= s_tdata[66:35];
                    vec_reg[2] <= s_tdata[98:67];
                    cnt_reg    <= AW'(1);
                    rmode_reg  <= (s_tuser == REQ_READ);
                    rzero_reg  <= !idx_ok;
                end
            end
            S_INT_ISS: ;
            S_INT_CAP: begin
                b_reg  <= rd_data;
                ax_reg <= 2'd0;
            end
            S_INT_ACC: begin
                b_reg.vel[ax_reg] <= gv;
                b_reg.pos[ax_reg] <= np;
                ax_reg <= ax_reg + 2'd1;
            end
            S_INT_WR: begin
                if (cnt_reg == LAST_A) begin
                    if (NODE_COUNT > 2) begin
                        back_reg <= 1'b1;
                        cnt_reg  <= BACK_A;
                    end else begin
                        back_reg <= 1'b0;
                        cnt_reg  <= AW'(1);
                    end
                end else begin
                    cnt_reg <= cnt_reg + AW'(1);
                end
            end
            S_P_CPA: apos_reg <= rd_data.pos;
            S_P_CPB: b_reg <= rd_data;
            S_P_DIF: begin
                d_reg  <= dif;
                s_reg  <= '0;
                ax_reg <= 2'd0;
            end
            S_P_SQACC: begin
                s_reg  <= s_reg + prod_reg[63:0];
                ax_reg <= ax_reg + 2'd1;
            end
            S_P_SQRT: mag_reg <= sqrt_root;
            S_P_K: begin
                k_reg    <= (kraw > {19'b0, pull_reg}) ? pull_reg : kraw[30:0];
                ax_reg   <= 2'd0;
                kick_reg <= 1'b0;
            end
            S_P_DIVW: begin
                if (div_done) begin
                    if (!kick_reg) begin
                        b_reg.pos[ax_reg] <= ld_pos;
                        kick_reg <= 1'b1;
                    end else begin
                        b_reg.vel[ax_reg] <= ld_vel;
                        kick_reg <= 1'b0;
                        ax_reg   <= ax_reg + 2'd1;
                    end
                end
            end
            S_P_WR: begin
                if (back_reg) begin
                    if (cnt_reg == AW'(1)) begin
                        back_reg <= 1'b0;
                    end else begin
                        cnt_reg <= cnt_reg - AW'(1);
                    end
                end else if (cnt_reg == LAST_A) begin
                    e_reg     <= 3'd0;
                    rmode_reg <= 1'b0;
                    rzero_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + AW'(1);
                end
            end
            S_E_CAP: begin
                if (slot_free) begin
                    m_data_reg <= {out_node_data.vel[2], out_node_data.vel[1],
                                   out_node_data.vel[0], out_node_data.pos[2],
                                   out_node_data.pos[1], out_node_data.pos[0],
                                   rmode_reg ? idx_reg : e_reg};
                    m_last_reg <= rmode_reg || e_reg == E_LAST;
                    e_reg      <= e_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg};
    assign m_tlast  = m_last_reg;

    rncs_mem #(
        .DEPTH(NODE_COUNT)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    rncs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (s_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    rncs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg[63:0]),
        .divisor  (mag_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

endmodule

[hdl/rncs_chk.sv]
`timescale 1ns / 1ps
module rncs_chk
    import rncs_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [2:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [199:0] m_tdata,
    input logic         m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == REQ_TICK |=> !s_tready)
        else $error("tick request did not hold off the next request");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == REQ_READ |=> !s_tready)
        else $error("read request did not hold off the next request");

endmodule

bind rope_node_chain_step_top rncs_chk u_chk (.*);
